@@ hdl/sfp_pkg.sv @@
// Shared types, codes and sizes for the servo response frame parser.
package sfp_pkg;

  localparam int MAX_FRAME = 16;
  localparam int FILL_W    = $clog2(MAX_FRAME + 1);
  localparam int MIN_FRAME = 6;
  localparam int LEN_EXTRA = 3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [2:0] REG_HEADER  = 3'd0;
  localparam logic [2:0] REG_ID      = 3'd1;
  localparam logic [2:0] REG_ANY_ID  = 3'd2;
  localparam logic [2:0] REG_COMMAND = 3'd3;
  localparam logic [2:0] REG_LEAST   = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] word_value;
    logic [4:0]  frame_length;
    logic [15:0] received_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  wanted_id;
    logic        any_id;
    logic [7:0]  wanted_command;
    logic [4:0]  least_length;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              waiting;
    logic [FILL_W-1:0] fill_count;
    logic [FILL_W-1:0] target_len;
    logic [7:0]        running_sum;
    logic [7:0]        got_id;
    logic [7:0]        got_command;
    logic [7:0]        param_low;
    logic [7:0]        param_high;
    logic [15:0]       byte_total;
    logic              bad_seen;
    logic [15:0]       elapsed;
  } parse_st_t;

endpackage

@@ hdl/sfp_cfg.sv @@
// Configuration register file of the servo response frame parser.
module sfp_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output sfp_pkg::cfg_t cfg
);
  import sfp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER:  cfg_nxt.header_byte    = cfg_data[7:0];
        REG_ID:      cfg_nxt.wanted_id      = cfg_data[7:0];
        REG_ANY_ID:  cfg_nxt.any_id         = cfg_data[0];
        REG_COMMAND: cfg_nxt.wanted_command = cfg_data[7:0];
        REG_LEAST:   cfg_nxt.least_length   = cfg_data[4:0];
        REG_TIMEOUT: cfg_nxt.timeout_ms     = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte    <= 8'd85;
      cfg_r.wanted_id      <= 8'd1;
      cfg_r.any_id         <= 1'b0;
      cfg_r.wanted_command <= 8'd0;
      cfg_r.least_length   <= 5'd8;
      cfg_r.timeout_ms     <= 16'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/sfp_step.sv @@
// Next-state and result logic for one input word of the frame parser.
module sfp_step (
  input  sfp_pkg::cfg_t      cfg,
  input  sfp_pkg::parse_st_t cur,
  input  sfp_pkg::in_word_t  item,
  output sfp_pkg::parse_st_t nxt,
  output logic               res_valid,
  output sfp_pkg::out_word_t res
);
  import sfp_pkg::*;

  localparam logic [FILL_W-1:0] IDX_HDR2 = FILL_W'(1);
  localparam logic [FILL_W-1:0] IDX_ID   = FILL_W'(2);
  localparam logic [FILL_W-1:0] IDX_LEN  = FILL_W'(3);
  localparam logic [FILL_W-1:0] IDX_CMD  = FILL_W'(4);
  localparam logic [FILL_W-1:0] IDX_PLO  = FILL_W'(5);
  localparam logic [FILL_W-1:0] IDX_PHI  = FILL_W'(6);

  logic [7:0]        sum_add;
  logic [FILL_W-1:0] fill_inc;
  logic [8:0]        size9;
  logic              bad_new;

  always_comb begin
    sum_add   = cur.running_sum + item.rx_byte;
    fill_inc  = cur.fill_count + FILL_W'(1);
    size9     = {1'b0, item.rx_byte} + 9'(LEN_EXTRA);
    bad_new   = cur.bad_seen | (cur.fill_count != '0);
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    case (item.kind)
      KIND_START: begin
        nxt         = '0;
        nxt.waiting = 1'b1;
      end
      KIND_BYTE: begin
        if (cur.waiting) begin
          if (cur.byte_total != 16'hFFFF) begin
            nxt.byte_total = cur.byte_total + 16'd1;
          end
          if (cur.fill_count == '0) begin
            if (item.rx_byte == cfg.header_byte) begin
              nxt.fill_count  = FILL_W'(1);
              nxt.running_sum = '0;
            end else begin
              nxt.bad_seen = 1'b1;
            end
          end else if (cur.fill_count == IDX_HDR2) begin
            if (item.rx_byte == cfg.header_byte) begin
              nxt.fill_count = FILL_W'(2);
            end else begin
              nxt.fill_count  = '0;
              nxt.target_len  = '0;
              nxt.running_sum = '0;
              nxt.bad_seen    = 1'b1;
            end
          end else if (cur.fill_count >= FILL_W'(MAX_FRAME)) begin
            nxt.fill_count  = '0;
            nxt.target_len  = '0;
            nxt.running_sum = '0;
            nxt.bad_seen    = 1'b1;
          end else begin
            nxt.fill_count = fill_inc;
            if (cur.fill_count == IDX_ID)  nxt.got_id      = item.rx_byte;
            if (cur.fill_count == IDX_CMD) nxt.got_command = item.rx_byte;
            if (cur.fill_count == IDX_PLO) nxt.param_low   = item.rx_byte;
            if (cur.fill_count == IDX_PHI) nxt.param_high  = item.rx_byte;
            if (cur.fill_count == IDX_LEN) begin
              nxt.running_sum = sum_add;
              if (size9 < 9'(MIN_FRAME) || size9 > 9'(MAX_FRAME)) begin
                nxt.fill_count  = '0;
                nxt.target_len  = '0;
                nxt.running_sum = '0;
                nxt.bad_seen    = 1'b1;
              end else begin
                nxt.target_len = FILL_W'(size9);
                nxt.param_high = '0;
              end
            end else if (cur.target_len == '0 || fill_inc < cur.target_len) begin
              nxt.running_sum = sum_add;
            end else if (int'(fill_inc) >= int'(cfg.least_length)
                         && (cfg.any_id || cur.got_id == cfg.wanted_id)
                         && cur.got_command == cfg.wanted_command
                         && item.rx_byte == ~cur.running_sum) begin
              nxt.fill_count         = '0;
              nxt.target_len         = '0;
              nxt.waiting            = 1'b0;
              res_valid              = 1'b1;
              res.status             = ST_OK;
              res.word_value         = {nxt.param_high, nxt.param_low};
              res.frame_length       = 5'(fill_inc);
              res.received_count     = nxt.byte_total;
            end else begin
              nxt.fill_count  = '0;
              nxt.target_len  = '0;
              nxt.running_sum = '0;
              nxt.bad_seen    = 1'b1;
            end
          end
        end
      end
      KIND_TICK: begin
        if (cur.waiting) begin
          if (cur.elapsed != 16'hFFFF) begin
            nxt.elapsed = cur.elapsed + 16'd1;
          end
          if (nxt.elapsed >= cfg.timeout_ms) begin
            nxt.bad_seen       = bad_new;
            nxt.fill_count     = '0;
            nxt.target_len     = '0;
            nxt.waiting        = 1'b0;
            res_valid          = 1'b1;
            res.status         = (cur.byte_total == '0 && !bad_new) ? ST_NO_DATA : ST_INVALID;
            res.received_count = cur.byte_total;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/servo_response_frame_parser.sv @@
// Top level of the servo response frame parser: input stage, state and result register.
//
//   channel | direction | payload         | handshake
//   in_     | input     | in_word_t       | in_valid / in_ready
//   out_    | output    | out_word_t      | out_valid / out_ready
//   cfg_    | input     | index + data    | cfg_valid / cfg_ready (always ready)
//
// One word per cycle while the result is not stalled: a word is held in the input
// register, is decoded in a single pass and its result lands in the output register.
// Reset (synchronous, rst_n low) clears the parser state and loads register defaults.
// A stalled result holds the input stage; in_ready drops only while both are full.
module servo_response_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfp_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sfp_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word_r;
  logic      in_valid_r;
  logic      in_valid_nxt;
  parse_st_t st_r;
  parse_st_t st_step;
  parse_st_t st_nxt;
  logic      res_valid;
  out_word_t res;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;
  logic      advance;

  sfp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfp_step u_step (
    .cfg       (cfg),
    .cur       (st_r),
    .item      (in_word_r),
    .nxt       (st_step),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      st_nxt       = st_step;
      in_valid_nxt = 1'b0;
      if (res_valid) begin
        out_valid_nxt = 1'b1;
      end
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (advance && res_valid) begin
      out_word_r <= res;
    end
  end

endmodule

@@ hdl/sfp_checker.sv @@
// Port-level checks of the servo response frame parser and their binding.
module sfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sfp_pkg::out_word_t out_data
);
  import sfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_NO_DATA
                  || out_data.status == ST_INVALID)
    else $error("unknown status code");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |->
      int'(out_data.frame_length) >= MIN_FRAME && int'(out_data.frame_length) <= MAX_FRAME
      && out_data.received_count >= 16'(MIN_FRAME))
    else $error("accepted frame length out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.word_value == '0 && out_data.frame_length == '0)
    else $error("failed wait reports frame data");

endmodule

bind servo_response_frame_parser sfp_checker u_sfp_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the servo response frame parser: directed table, random replies.
module tb;
  import sfp_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_WORDS  = 50;
  localparam int MAX_NOTES    = 40;

  typedef struct packed {
    in_word_t  w;
    logic      known;
    out_word_t res;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // register copies
  logic [7:0]  c_header  = 8'h55;
  logic [7:0]  c_id      = 8'h01;
  logic        c_any     = 1'b0;
  logic [7:0]  c_cmd     = 8'h00;
  logic [4:0]  c_least   = 5'd8;
  logic [15:0] c_timeout = 16'd20;

  // parser state copies
  logic        armed   = 1'b0;
  logic [4:0]  fill    = '0;
  logic [4:0]  fsize   = '0;
  logic [7:0]  csum    = '0;
  logic [7:0]  rid     = '0;
  logic [7:0]  rcmd    = '0;
  logic [7:0]  plo     = '0;
  logic [7:0]  phi     = '0;
  logic [15:0] nbytes  = '0;
  logic        saw_bad = 1'b0;
  logic [15:0] ticks   = '0;

  out_word_t reply_q[$];
  dir_row_t  script[$];

  int errors       = 0;
  int live_words   = 0;
  int results_seen = 0;
  int settings     = 0;
  int send_idle    = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;

  servo_response_frame_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic in_word_t word_of(input logic [1:0] kind, input logic [7:0] b);
    in_word_t w;
    w.kind    = kind;
    w.rx_byte = b;
    return w;
  endfunction

  function automatic void drop_frame();
    fill    = '0;
    fsize   = '0;
    csum    = '0;
    saw_bad = 1'b1;
  endfunction

  function automatic logic parse_word(input in_word_t w, output out_word_t r);
    logic [7:0] b;
    logic [4:0] idx;
    int         sz;
    b = w.rx_byte;
    r = '0;
    if (w.kind == KIND_START) begin
      armed = 1'b1; fill = '0; fsize = '0; csum = '0; rid = '0; rcmd = '0;
      plo = '0; phi = '0; nbytes = '0; saw_bad = 1'b0; ticks = '0;
      return 1'b0;
    end
    if (!armed) return 1'b0;
    if (w.kind == KIND_BYTE) begin
      if (nbytes != 16'hFFFF) nbytes = nbytes + 16'd1;
      if (fill == 5'd0) begin
        if (b == c_header) begin
          fill = 5'd1;
          csum = '0;
        end else begin
          saw_bad = 1'b1;
        end
        return 1'b0;
      end
      if (fill == 5'd1) begin
        if (b == c_header) fill = 5'd2;
        else drop_frame();
        return 1'b0;
      end
      if (fill >= MAX_FRAME) begin
        drop_frame();
        return 1'b0;
      end
      idx  = fill;
      fill = fill + 5'd1;
      case (idx)
        5'd2: rid  = b;
        5'd4: rcmd = b;
        5'd5: plo  = b;
        5'd6: phi  = b;
        default: ;
      endcase
      if (fill == 5'd4) begin
        sz   = b + LEN_EXTRA;
        csum = csum + b;
        if (sz < MIN_FRAME || sz > MAX_FRAME) begin
          drop_frame();
        end else begin
          fsize = sz[4:0];
          phi   = '0;
        end
        return 1'b0;
      end
      if (fsize == 5'd0 || fill < fsize) begin
        csum = csum + b;
        return 1'b0;
      end
      if (fill >= c_least && (c_any || rid == c_id) && rcmd == c_cmd &&
          (b ^ csum) == 8'hFF) begin
        r.status         = ST_OK;
        r.word_value     = {phi, plo};
        r.frame_length   = fill;
        r.received_count = nbytes;
        fill  = '0;
        fsize = '0;
        armed = 1'b0;
        return 1'b1;
      end
      drop_frame();
      return 1'b0;
    end
    if (w.kind == KIND_TICK) begin
      if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
      if (ticks >= c_timeout) begin
        if (fill != 5'd0) saw_bad = 1'b1;
        r.status         = (nbytes == 16'd0 && !saw_bad) ? ST_NO_DATA : ST_INVALID;
        r.received_count = nbytes;
        fill  = '0;
        fsize = '0;
        armed = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_NOTES) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEADER:  c_header  = val[7:0];
      REG_ID:      c_id      = val[7:0];
      REG_ANY_ID:  c_any     = val[0];
      REG_COMMAND: c_cmd     = val[7:0];
      REG_LEAST:   c_least   = val[4:0];
      REG_TIMEOUT: c_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_word(input in_word_t w, input logic known, input out_word_t typed);
    out_word_t r;
    logic      hit;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    if (w.kind == KIND_START || (armed && w.kind != KIND_NONE)) live_words++;
    hit = parse_word(w, r);
    if (known) reply_q.push_back(typed);
    else if (hit) reply_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [7:0] b, input logic known,
                         input logic [1:0] st, input logic [15:0] wv, input logic [4:0] len,
                         input logic [15:0] cnt);
    dir_row_t row;
    row.w                  = word_of(kind, b);
    row.known              = known;
    row.res.status         = st;
    row.res.word_value     = wv;
    row.res.frame_length   = len;
    row.res.received_count = cnt;
    script.push_back(row);
  endtask

  // one reply: mostly a well-formed frame with random content, some noise and damage
  task automatic play_reply();
    in_word_t   seq[$];
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] lenb;
    int         sz;
    int         lo;
    int         k;
    if ($urandom_range(0, 9) != 0)
      seq.push_back(word_of(KIND_START, 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        seq.push_back(word_of(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 3))
        seq.push_back(word_of(KIND_BYTE, 8'($urandom_range(0, 255))));
      repeat (c_timeout > 60 ? 60 : c_timeout) seq.push_back(word_of(KIND_TICK, 8'h00));
    end else begin
      lo   = c_least > MIN_FRAME ? int'(c_least) : MIN_FRAME;
      sz   = int'($urandom_range(lo, MAX_FRAME));
      lenb = 8'(sz - LEN_EXTRA);
      if ($urandom_range(0, 9) == 0) lenb = 8'($urandom_range(0, 255));
      body.push_back(c_header);
      body.push_back(c_header);
      body.push_back($urandom_range(0, 9) < 8 ? c_id : 8'($urandom_range(0, 255)));
      body.push_back(lenb);
      body.push_back($urandom_range(0, 9) < 9 ? c_cmd : 8'($urandom_range(0, 255)));
      repeat (sz - 6) body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) body[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
      sum = '0;
      for (k = 2; k < body.size(); k++) sum = sum + body[k];
      body.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : ~sum);
      foreach (body[j]) begin
        if ($urandom_range(0, 19) == 0)
          seq.push_back(word_of(KIND_TICK, 8'($urandom_range(0, 255))));
        seq.push_back(word_of(KIND_BYTE, body[j]));
      end
    end
    foreach (seq[j]) send_word(seq[j], 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (reply_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d count %0d",
                                out_data.status, out_data.received_count));
      end else begin
        e = reply_q.pop_front();
        if (out_data.status !== e.status)
          note_mismatch($sformatf("status %0d, want %0d", out_data.status, e.status));
        if (out_data.word_value !== e.word_value)
          note_mismatch($sformatf("word_value %h, want %h", out_data.word_value, e.word_value));
        if (out_data.frame_length !== e.frame_length)
          note_mismatch($sformatf("frame_length %0d, want %0d",
                                  out_data.frame_length, e.frame_length));
        if (out_data.received_count !== e.received_count)
          note_mismatch($sformatf("received_count %0d, want %0d",
                                  out_data.received_count, e.received_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results pending",
               idle_cycles, reply_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    int start_words;
    logic paused;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_TIMEOUT, 16'd1);
    settings++;
    add_row(KIND_TICK,  8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'hFF, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_NONE,  8'h55, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_START, 8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h55, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h55, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h01, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h05, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'hFF, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'hFF, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'hFB, 1'b1, ST_OK, 16'hFFFF, 5'd8, 16'd8);
    add_row(KIND_START, 8'hFF, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_START, 8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_TICK,  8'hFF, 1'b1, ST_NO_DATA, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_START, 8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_TICK,  8'h00, 1'b1, ST_INVALID, 16'h0000, 5'd0, 16'd1);
    add_row(KIND_START, 8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h55, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h55, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h01, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_BYTE,  8'h00, 1'b0, ST_OK, 16'h0000, 5'd0, 16'd0);
    add_row(KIND_TICK,  8'h00, 1'b1, ST_INVALID, 16'h0000, 5'd0, 16'd4);
    foreach (script[i]) send_word(script[i].w, script[i].known, script[i].res);

    for (p = 0; p < 6; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 67; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 67; end
        default: begin send_idle = 8; stall_pct = 8; end
      endcase
      if (p == 0) begin
        cfg_write(REG_HEADER, 16'h0000);
        cfg_write(REG_ID, 16'h0000);
        cfg_write(REG_ANY_ID, 16'h0000);
        cfg_write(REG_COMMAND, 16'h0000);
        cfg_write(REG_LEAST, 16'd1);
        cfg_write(REG_TIMEOUT, 16'd1);
      end else if (p == 1) begin
        cfg_write(REG_HEADER, 16'h00FF);
        cfg_write(REG_ID, 16'h00FF);
        cfg_write(REG_ANY_ID, 16'h0001);
        cfg_write(REG_COMMAND, 16'h00FF);
        cfg_write(REG_LEAST, 16'd16);
        cfg_write(REG_TIMEOUT, 16'hFFFF);
      end else begin
        cfg_write(REG_HEADER, 16'($urandom_range(0, 255)));
        cfg_write(REG_ID, 16'($urandom_range(0, 255)));
        cfg_write(REG_ANY_ID, 16'($urandom_range(0, 1)));
        cfg_write(REG_COMMAND, 16'($urandom_range(0, 255)));
        cfg_write(REG_LEAST, 16'($urandom_range(1, 16)));
        cfg_write(REG_TIMEOUT, 16'($urandom_range(1, 40)));
      end
      settings++;
      start_words = live_words;
      paused = 1'b0;
      while (live_words - start_words < PHASE_WORDS) begin
        play_reply();
        if (!paused && live_words - start_words >= PHASE_WORDS / 2) begin
          wait_results();
          paused = 1'b1;
        end
      end
    end

    // hold the receiver off while timeouts pile up behind it
    settle();
    send_idle = 0;
    stall_pct = 0;
    cfg_write(REG_TIMEOUT, 16'd1);
    settings++;
    hold_asks++;
    repeat (30) begin
      send_word(word_of(KIND_START, 8'($urandom_range(0, 255))), 1'b0, '0);
      send_word(word_of(KIND_TICK, 8'($urandom_range(0, 255))), 1'b0, '0);
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d live input words, %0d results, %0d register settings",
             live_words, results_seen, settings);
    $display("including valid frames, bad checks, resyncs, bad lengths, timeouts and hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
